// ===== hw/rtl/gmb_pkg.sv =====
// Shared types and constants of the greedy meshlet builder.
// Used by the slot cells, the cell row, the top level and its checker.
package gmb_pkg;

	localparam int VC_W   = 7;
	localparam int TC_W   = 9;
	localparam int VTX_W  = 32;
	localparam int LOC_W  = 6;
	localparam int KIND_W = 2;
	localparam int CIDX_W = 8;
	localparam int CDAT_W = 9;

	localparam int MAX_VERTS = 64;
	localparam int MAX_TRIS  = 256;

	localparam logic [KIND_W-1:0] KIND_VERT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TRI   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_MAX_TRIS  = 8'd0;
	localparam logic [CIDX_W-1:0] CFG_MAX_VERTS = 8'd1;

	localparam logic [TC_W-1:0] RST_MAX_TRIS  = 9'd124;
	localparam logic [VC_W-1:0] RST_MAX_VERTS = 7'd64;
	localparam logic [VC_W-1:0] MIN_VERTS     = 7'd3;

	localparam int PEND_W = 5;
	localparam logic [PEND_W-1:0] PEND_CLOSE = 5'b00001;
	localparam logic [PEND_W-1:0] PEND_A     = 5'b00010;
	localparam logic [PEND_W-1:0] PEND_B     = 5'b00100;
	localparam logic [PEND_W-1:0] PEND_C     = 5'b01000;
	localparam logic [PEND_W-1:0] PEND_TRI   = 5'b10000;

	typedef struct packed {
		logic [2:0]      hit;
		logic [VC_W-1:0] sa;
		logic [VC_W-1:0] sb;
		logic [VC_W-1:0] sc;
	} lookup_t;

	typedef struct packed {
		logic [2:0]      en;
		logic [VC_W-1:0] sa;
		logic [VC_W-1:0] sb;
		logic [VC_W-1:0] sc;
	} slot_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

// ===== hw/rtl/gmb_cell.sv =====
// One slot cell: holds the global vertex of one local slot and matches it
// against the three corners. Depends on gmb_pkg.
module gmb_cell #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic [31:0]           query_a,
	input  logic [31:0]           query_b,
	input  logic [31:0]           query_c,
	input  logic [6:0]            used,
	input  gmb_pkg::slot_wr_t     wr,
	input  gmb_pkg::lookup_t      chain_in,
	output gmb_pkg::lookup_t      chain_out
);
	import gmb_pkg::*;

	logic [VTX_W-1:0] vertex_q;
	logic             in_use;
	logic [2:0]       mine;
	logic [VC_W-1:0]  own;

	always_ff @(posedge clk) begin
		if (wr.en[0] && 32'(wr.sa) == IDX) begin
			vertex_q <= query_a;
		end else if (wr.en[1] && 32'(wr.sb) == IDX) begin
			vertex_q <= query_b;
		end else if (wr.en[2] && 32'(wr.sc) == IDX) begin
			vertex_q <= query_c;
		end
	end

	assign in_use = 32'(used) > IDX;
	assign own    = VC_W'(IDX);
	assign mine   = {3{in_use}} & {vertex_q == query_c, vertex_q == query_b,
		vertex_q == query_a};

	always_comb begin
		chain_out     = chain_in;
		chain_out.hit = chain_in.hit | mine;
		chain_out.sa  = chain_in.sa | (mine[0] ? own : '0);
		chain_out.sb  = chain_in.sb | (mine[1] ? own : '0);
		chain_out.sc  = chain_in.sc | (mine[2] ? own : '0);
	end

endmodule

// ===== hw/rtl/gmb_cell_row.sv =====
// Row of slot cells; the match result is passed from cell to cell.
// Depends on gmb_pkg and gmb_cell.
module gmb_cell_row (
	input  logic                  clk,
	input  logic [31:0]           query_a,
	input  logic [31:0]           query_b,
	input  logic [31:0]           query_c,
	input  logic [6:0]            used,
	input  gmb_pkg::slot_wr_t     wr,
	output gmb_pkg::lookup_t      result
);
	import gmb_pkg::*;

	lookup_t chain [MAX_VERTS+1];

	assign chain[0] = '0;

	for (genvar i = 0; i < MAX_VERTS; i++) begin : g_cell
		gmb_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.query_a   (query_a),
			.query_b   (query_b),
			.query_c   (query_c),
			.used      (used),
			.wr        (wr),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	assign result = chain[MAX_VERTS];

endmodule

// ===== hw/rtl/greedy_meshlet_builder_unit.sv =====
// Top level of the greedy meshlet builder: request handling, slot lookup
// decision, result sequencing. Depends on gmb_pkg and gmb_cell_row.
//
// Usage: each input request carries mode and three global vertex indices.
// Mode 0 adds a triangle, mode 1 ends the mesh. While the receiver is
// ready, results leave one per cycle on the output channel: an optional
// close record, up to three new vertex entries and the local triangle,
// the last one flagged by last_of_run. An end request gives one close
// record or nothing. A triangle request is accepted in the idle state and
// then goes through the slot lookup, in which every cell of the row compares
// its vertex with all three corners, before its results are emitted.
// The next request is accepted once the last result has been loaded into
// the output register, so it may still be waiting there.
// Configuration writes go to their own channel, always ready. Register 0 is
// max_triangles, 1 is max_vertices. The user must make the writes while the
// block is idle; the block itself does not enforce this. Reset restores the
// limits to 124 and 64 and empties the open meshlet.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; no result is lost.
module greedy_meshlet_builder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [gmb_pkg::VTX_W-1:0]     vertex_a,
	input  logic [gmb_pkg::VTX_W-1:0]     vertex_b,
	input  logic [gmb_pkg::VTX_W-1:0]     vertex_c,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gmb_pkg::KIND_W-1:0]    kind,
	output logic [gmb_pkg::VTX_W-1:0]     global_vertex,
	output logic [gmb_pkg::LOC_W-1:0]     local_0,
	output logic [gmb_pkg::LOC_W-1:0]     local_1,
	output logic [gmb_pkg::LOC_W-1:0]     local_2,
	output logic [gmb_pkg::VC_W-1:0]      vertex_count,
	output logic [gmb_pkg::TC_W-1:0]      triangle_count,
	output logic [31:0]                   meshlet_index,
	output logic                          last_of_run,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gmb_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [gmb_pkg::CDAT_W-1:0]    cfg_data
);
	import gmb_pkg::*;

	state_t state_q;
	logic [TC_W-1:0]   max_tris_q;
	logic [VC_W-1:0]   max_verts_q;
	logic [VC_W-1:0]   used_slots_q;
	logic [TC_W-1:0]   used_tris_q;
	logic [31:0]       md_q;
	logic [31:0]       md_close_q;
	logic [VC_W-1:0]   close_vc_q;
	logic [TC_W-1:0]   close_tc_q;
	logic [PEND_W-1:0] pend_q;
	logic [VTX_W-1:0]  va_q, vb_q, vc_q;
	logic [VC_W-1:0]   sa_q, sb_q, sc_q;
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [VTX_W-1:0]  gv_q;
	logic [LOC_W-1:0]  l0_q, l1_q, l2_q;
	logic [VC_W-1:0]   ovc_q;
	logic [TC_W-1:0]   otc_q;
	logic [31:0]       omi_q;
	logic              last_q;

	lookup_t   lk;
	slot_wr_t  wr;
	logic [TC_W-1:0] lim_t;
	logic [VC_W-1:0] lim_v;
	logic       ha, hb, hc, eq_ba, eq_ca, eq_cb;
	logic [1:0] fresh;
	logic       do_close, new_a, new_b, new_c;
	logic [VC_W-1:0] base, sa, sb, sc, cnt1, cnt2, cnt3;
	logic [PEND_W-1:0] pick, rest;
	logic       in_acc, load;

	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign load      = state_q == ST_EMIT && pend_q != '0 && (!out_valid_q || out_ready);

	gmb_cell_row u_row (
		.clk     (clk),
		.query_a (va_q),
		.query_b (vb_q),
		.query_c (vc_q),
		.used    (used_slots_q),
		.wr      (wr),
		.result  (lk)
	);

	always_comb begin
		lim_t = max_tris_q;
		if (max_tris_q == '0) begin
			lim_t = TC_W'(1);
		end else if (32'(max_tris_q) > MAX_TRIS) begin
			lim_t = TC_W'(MAX_TRIS);
		end
		lim_v = max_verts_q;
		if (max_verts_q < MIN_VERTS) begin
			lim_v = MIN_VERTS;
		end else if (32'(max_verts_q) > MAX_VERTS) begin
			lim_v = VC_W'(MAX_VERTS);
		end
	end

	always_comb begin
		eq_ba = vb_q == va_q;
		eq_ca = vc_q == va_q;
		eq_cb = vc_q == vb_q;
		fresh = 2'(!lk.hit[0]) + 2'(!lk.hit[1] && !eq_ba)
			+ 2'(!lk.hit[2] && !eq_ca && !eq_cb);
		do_close = ({1'b0, used_tris_q} + 10'd1 > {1'b0, lim_t})
			|| ({1'b0, used_slots_q} + 8'(fresh) > {1'b0, lim_v});
		ha   = lk.hit[0] && !do_close;
		hb   = lk.hit[1] && !do_close;
		hc   = lk.hit[2] && !do_close;
		base = do_close ? '0 : used_slots_q;
		new_a = !ha;
		sa    = ha ? lk.sa : base;
		cnt1  = base + VC_W'(new_a);
		new_b = !hb && !eq_ba;
		sb    = hb ? lk.sb : (eq_ba ? sa : cnt1);
		cnt2  = cnt1 + VC_W'(new_b);
		new_c = !hc && !eq_ca && !eq_cb;
		sc    = hc ? lk.sc : (eq_ca ? sa : (eq_cb ? sb : cnt2));
		cnt3  = cnt2 + VC_W'(new_c);
		wr.en = {new_c, new_b, new_a} & {3{state_q == ST_LOOK}};
		wr.sa = sa;
		wr.sb = sb;
		wr.sc = sc;
	end

	assign pick = pend_q & (~pend_q + PEND_W'(1));
	assign rest = pend_q & ~pick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_tris_q   <= RST_MAX_TRIS;
			max_verts_q  <= RST_MAX_VERTS;
			used_slots_q <= '0;
			used_tris_q  <= '0;
			md_q         <= '0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAX_TRIS) begin
					max_tris_q <= cfg_data;
				end else if (cfg_index == CFG_MAX_VERTS) begin
					max_verts_q <= cfg_data[VC_W-1:0];
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (mode) begin
							used_slots_q <= '0;
							used_tris_q  <= '0;
							md_q         <= '0;
							if (used_tris_q != '0) begin
								pend_q  <= PEND_CLOSE;
								state_q <= ST_EMIT;
							end
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					pend_q <= PEND_TRI | (new_c ? PEND_C : '0) | (new_b ? PEND_B : '0)
						| (new_a ? PEND_A : '0) | (do_close ? PEND_CLOSE : '0);
					used_slots_q <= cnt3;
					used_tris_q  <= (do_close ? '0 : used_tris_q) + TC_W'(1);
					md_q         <= md_q + 32'(do_close);
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						pend_q <= rest;
						if (rest == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			va_q       <= vertex_a;
			vb_q       <= vertex_b;
			vc_q       <= vertex_c;
			md_close_q <= md_q;
			close_vc_q <= used_slots_q;
			close_tc_q <= used_tris_q;
		end
		if (state_q == ST_LOOK) begin
			sa_q <= sa;
			sb_q <= sb;
			sc_q <= sc;
		end
		if (load) begin
			last_q <= rest == '0;
			case (pick)
				PEND_CLOSE: begin
					kind_q <= KIND_CLOSE;
					gv_q   <= '0;
					l0_q   <= '0;
					l1_q   <= '0;
					l2_q   <= '0;
					ovc_q  <= close_vc_q;
					otc_q  <= close_tc_q;
					omi_q  <= md_close_q;
				end
				PEND_A: begin
					kind_q <= KIND_VERT;
					gv_q   <= va_q;
					l0_q   <= sa_q[LOC_W-1:0];
					l1_q   <= '0;
					l2_q   <= '0;
					ovc_q  <= '0;
					otc_q  <= '0;
					omi_q  <= md_q;
				end
				PEND_B: begin
					kind_q <= KIND_VERT;
					gv_q   <= vb_q;
					l0_q   <= sb_q[LOC_W-1:0];
					l1_q   <= '0;
					l2_q   <= '0;
					ovc_q  <= '0;
					otc_q  <= '0;
					omi_q  <= md_q;
				end
				PEND_C: begin
					kind_q <= KIND_VERT;
					gv_q   <= vc_q;
					l0_q   <= sc_q[LOC_W-1:0];
					l1_q   <= '0;
					l2_q   <= '0;
					ovc_q  <= '0;
					otc_q  <= '0;
					omi_q  <= md_q;
				end
				default: begin
					kind_q <= KIND_TRI;
					gv_q   <= '0;
					l0_q   <= sa_q[LOC_W-1:0];
					l1_q   <= sb_q[LOC_W-1:0];
					l2_q   <= sc_q[LOC_W-1:0];
					ovc_q  <= '0;
					otc_q  <= '0;
					omi_q  <= md_q;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign global_vertex  = gv_q;
	assign local_0        = l0_q;
	assign local_1        = l1_q;
	assign local_2        = l2_q;
	assign vertex_count   = ovc_q;
	assign triangle_count = otc_q;
	assign meshlet_index  = omi_q;
	assign last_of_run    = last_q;

endmodule

// ===== hw/rtl/gmb_checker.sv =====
// Port-level checks of the greedy meshlet builder, bound to its top level.
// Depends on gmb_pkg and greedy_meshlet_builder_unit.
module gmb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       mode,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [gmb_pkg::KIND_W-1:0] kind,
	input logic [gmb_pkg::VTX_W-1:0]  global_vertex,
	input logic                       last_of_run
);
	import gmb_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind)
			&& $stable(global_vertex) && $stable(last_of_run))
		else $error("stalled result changed");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !mode |=> !in_ready)
		else $error("request accepted while previous one still in work");

	a_tri_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TRI |-> last_of_run)
		else $error("local triangle not flagged last");

	a_vert_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_VERT |-> !last_of_run)
		else $error("vertex entry flagged last");

endmodule

bind greedy_meshlet_builder_unit gmb_checker u_gmb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.mode          (mode),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.global_vertex (global_vertex),
	.last_of_run   (last_of_run)
);

// ===== verif/testbench.sv =====
// Testbench for greedy_meshlet_builder_unit: a scoreboard class predicts the result stream
// of every accepted request and checks the block's results in order, under random stalls.
// Depends on gmb_pkg and the block's RTL only.
`timescale 1ns / 1ps

typedef struct packed {
	logic [gmb_pkg::KIND_W-1:0] kind;
	logic [gmb_pkg::VTX_W-1:0]  global_vertex;
	logic [gmb_pkg::LOC_W-1:0]  local_0;
	logic [gmb_pkg::LOC_W-1:0]  local_1;
	logic [gmb_pkg::LOC_W-1:0]  local_2;
	logic [gmb_pkg::VC_W-1:0]   vertex_count;
	logic [gmb_pkg::TC_W-1:0]   triangle_count;
	logic [31:0]                meshlet_index;
	logic                       last_of_run;
} meshlet_result_t;

class meshlet_scoreboard;
	logic [gmb_pkg::VTX_W-1:0] slot_vtx[64];
	logic [gmb_pkg::VC_W-1:0]  used_slots;
	logic [gmb_pkg::TC_W-1:0]  used_tris;
	logic [31:0]               meshlets_done;
	logic [gmb_pkg::TC_W-1:0]  reg_max_tris;
	logic [gmb_pkg::VC_W-1:0]  reg_max_verts;
	meshlet_result_t           expected_q[$];
	int                        errors;
	int                        results_checked;
	int                        closes_seen;

	function new();
		used_slots    = '0;
		used_tris     = '0;
		meshlets_done = '0;
		reg_max_tris  = gmb_pkg::RST_MAX_TRIS;
		reg_max_verts = gmb_pkg::RST_MAX_VERTS;
		errors          = 0;
		results_checked = 0;
		closes_seen     = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void set_register(logic [gmb_pkg::CIDX_W-1:0] idx, logic [gmb_pkg::CDAT_W-1:0] data);
		if (idx == gmb_pkg::CFG_MAX_TRIS) begin
			reg_max_tris = data[gmb_pkg::TC_W-1:0];
		end else if (idx == gmb_pkg::CFG_MAX_VERTS) begin
			reg_max_verts = data[gmb_pkg::VC_W-1:0];
		end
	endfunction

	function int find_slot(logic [gmb_pkg::VTX_W-1:0] v);
		for (int s = 0; s < int'(used_slots) && s < 64; s++) begin
			if (slot_vtx[s] == v) return s;
		end
		return -1;
	endfunction

	function meshlet_result_t make_result(logic [gmb_pkg::KIND_W-1:0] k,
			logic [gmb_pkg::VTX_W-1:0] gv, logic [gmb_pkg::LOC_W-1:0] l0,
			logic [gmb_pkg::LOC_W-1:0] l1, logic [gmb_pkg::LOC_W-1:0] l2,
			logic [gmb_pkg::VC_W-1:0] vc, logic [gmb_pkg::TC_W-1:0] tc);
		meshlet_result_t r;
		r.kind           = k;
		r.global_vertex  = gv;
		r.local_0        = l0;
		r.local_1        = l1;
		r.local_2        = l2;
		r.vertex_count   = vc;
		r.triangle_count = tc;
		r.meshlet_index  = meshlets_done;
		r.last_of_run    = 1'b0;
		return r;
	endfunction

	function meshlet_result_t take_close();
		meshlet_result_t r;
		r = make_result(gmb_pkg::KIND_CLOSE, '0, '0, '0, '0, used_slots, used_tris);
		meshlets_done = meshlets_done + 32'd1;
		used_slots    = '0;
		used_tris     = '0;
		return r;
	endfunction

	function void note_request(logic m, logic [31:0] a, logic [31:0] b, logic [31:0] c);
		meshlet_result_t          run[5];
		logic [31:0]              corner[3];
		logic [gmb_pkg::LOC_W-1:0] loc[3];
		int                       n;
		int                       lim_t;
		int                       lim_v;
		int                       fresh;
		int                       s;
		bit                       seen;
		n = 0;
		if (m) begin
			if (used_tris > 0) begin
				run[n] = take_close();
				n++;
			end
			used_slots    = '0;
			used_tris     = '0;
			meshlets_done = '0;
		end else begin
			lim_t = int'(reg_max_tris);
			if (lim_t < 1) lim_t = 1;
			if (lim_t > 256) lim_t = 256;
			lim_v = int'(reg_max_verts);
			if (lim_v < 3) lim_v = 3;
			if (lim_v > 64) lim_v = 64;
			corner[0] = a;
			corner[1] = b;
			corner[2] = c;
			fresh = 0;
			for (int j = 0; j < 3; j++) begin
				seen = find_slot(corner[j]) >= 0;
				for (int i = 0; i < j; i++) begin
					if (corner[i] == corner[j]) seen = 1'b1;
				end
				if (!seen) fresh++;
			end
			if (int'(used_tris) + 1 > lim_t || int'(used_slots) + fresh > lim_v) begin
				run[n] = take_close();
				n++;
			end
			for (int j = 0; j < 3; j++) begin
				s = find_slot(corner[j]);
				if (s < 0 && used_slots < 64) begin
					s = int'(used_slots);
					slot_vtx[s] = corner[j];
					used_slots = used_slots + 1'b1;
					run[n] = make_result(gmb_pkg::KIND_VERT, corner[j], s[5:0], '0, '0, '0, '0);
					n++;
				end
				loc[j] = (s < 0) ? '0 : s[5:0];
			end
			run[n] = make_result(gmb_pkg::KIND_TRI, '0, loc[0], loc[1], loc[2], '0, '0);
			n++;
			used_tris = used_tris + 1'b1;
		end
		if (n > 0) run[n-1].last_of_run = 1'b1;
		for (int j = 0; j < n; j++) expected_q.insert(expected_q.size(), run[j]);
	endfunction

	function void show(string what, meshlet_result_t r);
		$display("  %s kind=%0d gv=%h l=%0d/%0d/%0d vc=%0d tc=%0d idx=%0d last=%0d", what,
			r.kind, r.global_vertex, r.local_0, r.local_1, r.local_2,
			r.vertex_count, r.triangle_count, r.meshlet_index, r.last_of_run);
	endfunction

	function void check_result(meshlet_result_t act);
		meshlet_result_t exp_r;
		results_checked++;
		if (expected_q.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("result %0d arrived with nothing expected", results_checked);
				show("got     ", act);
			end
			return;
		end
		exp_r = expected_q.pop_front();
		if (exp_r.kind == gmb_pkg::KIND_CLOSE) closes_seen++;
		if (act !== exp_r) begin
			errors++;
			if (errors <= 10) begin
				$display("result %0d differs", results_checked);
				show("expected", exp_r);
				show("got     ", act);
			end
		end
	endfunction

	function void check_drained();
		if (expected_q.size() != 0) begin
			errors += expected_q.size();
			$display("%0d expected results never arrived", expected_q.size());
		end
	endfunction
endclass

module testbench;
	localparam int LIMIT         = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int LONG_HOLD     = 300;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          mode;
	logic [gmb_pkg::VTX_W-1:0]     vertex_a;
	logic [gmb_pkg::VTX_W-1:0]     vertex_b;
	logic [gmb_pkg::VTX_W-1:0]     vertex_c;
	logic                          out_valid;
	logic                          out_ready;
	logic [gmb_pkg::KIND_W-1:0]    kind;
	logic [gmb_pkg::VTX_W-1:0]     global_vertex;
	logic [gmb_pkg::LOC_W-1:0]     local_0;
	logic [gmb_pkg::LOC_W-1:0]     local_1;
	logic [gmb_pkg::LOC_W-1:0]     local_2;
	logic [gmb_pkg::VC_W-1:0]      vertex_count;
	logic [gmb_pkg::TC_W-1:0]      triangle_count;
	logic [31:0]                   meshlet_index;
	logic                          last_of_run;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [gmb_pkg::CIDX_W-1:0]    cfg_index;
	logic [gmb_pkg::CDAT_W-1:0]    cfg_data;

	meshlet_scoreboard sb;
	bit                calm;
	bit                long_hold;
	int                cycles;
	int                n_requests;
	int                n_settings;
	logic [31:0]       recent_vtx[$];

	greedy_meshlet_builder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.vertex_a       (vertex_a),
		.vertex_b       (vertex_b),
		.vertex_c       (vertex_c),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.global_vertex  (global_vertex),
		.local_0        (local_0),
		.local_1        (local_1),
		.local_2        (local_2),
		.vertex_count   (vertex_count),
		.triangle_count (triangle_count),
		.meshlet_index  (meshlet_index),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic logic [31:0] pick_vertex(int reuse);
		logic [31:0] v;
		int          r;
		if (recent_vtx.size() > 0 && $urandom_range(0, 99) < reuse) begin
			v = recent_vtx[$urandom_range(0, recent_vtx.size() - 1)];
		end else begin
			r = $urandom_range(0, 7);
			case (r)
				0: begin
					v = 32'h0000_0000;
				end
				1: begin
					v = 32'hFFFF_FFFF;
				end
				2: begin
					v = $urandom_range(0, 31);
				end
				default: begin
					v = $urandom;
				end
			endcase
		end
		recent_vtx.insert(recent_vtx.size(), v);
		if (recent_vtx.size() > 12) void'(recent_vtx.pop_front());
		return v;
	endfunction

	task automatic send_request(input logic m, input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		vertex_a <= a;
		vertex_b <= b;
		vertex_c <= c;
		do @(posedge clk); while (!in_ready);
		sb.note_request(m, a, b, c);
		n_requests++;
	endtask

	task automatic send_tri(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
		send_request(1'b0, a, b, c);
	endtask

	task automatic send_end(input logic [31:0] junk);
		send_request(1'b1, junk, ~junk, junk ^ 32'h0F0F_0F0F);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [gmb_pkg::CIDX_W-1:0] idx,
			input logic [gmb_pkg::CDAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_limits(input logic [gmb_pkg::CDAT_W-1:0] tris,
			input logic [gmb_pkg::CDAT_W-1:0] verts);
		settle();
		write_register(gmb_pkg::CFG_MAX_TRIS, tris);
		write_register(gmb_pkg::CFG_MAX_VERTS, verts);
		n_settings++;
	endtask

	initial begin : result_sink
		int              stall;
		meshlet_result_t act;
		out_ready = 1'b0;
		wait (sb != null);
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end
			stall = calm ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			act = '{kind, global_vertex, local_0, local_1, local_2,
				vertex_count, triangle_count, meshlet_index, last_of_run};
			sb.check_result(act);
		end
	end

	initial begin : request_source
		int tris_set[8];
		int verts_set[8];
		int reuse;
		int count;
		in_valid   = 1'b0;
		mode       = 1'b0;
		vertex_a   = '0;
		vertex_b   = '0;
		vertex_c   = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		calm       = 1'b0;
		long_hold  = 1'b0;
		n_requests = 0;
		n_settings = 1;
		sb = new();
		tris_set  = '{256, 1, 124, 2, 511, 40, 0, 0};
		verts_set = '{64, 3, 9'h182, 64, 127, 5, 0, 0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Limits at their reset values first.
		send_tri(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
		send_tri(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		send_tri(32'd7, 32'd7, 32'd7);
		send_tri(32'd9, 32'd9, 32'd10);
		send_tri(32'd11, 32'd12, 32'd11);
		send_tri(32'd13, 32'd14, 32'd14);
		send_tri(32'h0000_0000, 32'd7, 32'hFFFF_FFFF);
		send_end(32'h5555_5555);
		send_end(32'hAAAA_AAAA);
		send_tri(32'd1, 32'd2, 32'd3);

		apply_limits(9'd1, 9'd3);
		send_tri(32'd1, 32'd2, 32'd3);
		send_tri(32'd1, 32'd2, 32'd3);
		send_tri(32'd4, 32'd5, 32'd6);

		apply_limits(9'd0, 9'd0);
		write_register(8'hFF, 9'h1FF);
		send_tri(32'd1, 32'd2, 32'd3);
		send_tri(32'd3, 32'd4, 32'd3);
		send_end(32'h1234_5678);

		apply_limits(9'd3, 9'd4);
		send_tri(32'd1, 32'd2, 32'd3);
		send_tri(32'd1, 32'd2, 32'd4);
		send_tri(32'd1, 32'd5, 32'd6);
		send_tri(32'd5, 32'd6, 32'd5);
		send_tri(32'd5, 32'd6, 32'd7);
		send_tri(32'd5, 32'd6, 32'd7);
		send_end(32'hFFFF_FFFF);
		send_end(32'h0000_0000);

		for (int p = 0; p < 8; p++) begin
			if (p >= 6) begin
				tris_set[p]  = $urandom_range(0, 511);
				verts_set[p] = $urandom_range(0, 511);
			end
			apply_limits(tris_set[p][8:0], verts_set[p][8:0]);
			reuse = (p == 0) ? 10 : 70;
			count = (p == 0) ? 24 : 17;
			calm = (p == 2 || p == 3);
			if (p == 3) long_hold = 1'b1;
			for (int k = 0; k < count; k++) begin
				if (p == 5 && k == 11) settle();
				if ($urandom_range(0, 9) == 0) begin
					send_end($urandom);
				end else begin
					send_tri(pick_vertex(reuse), pick_vertex(reuse), pick_vertex(reuse));
				end
			end
			calm = 1'b0;
		end

		settle();
		sb.check_drained();
		$display("run covered %0d requests under %0d limit settings", n_requests, n_settings);
		$display("%0d results checked, %0d meshlets closed", sb.results_checked, sb.closes_seen);
		if (sb.errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end
endmodule

// ===== greedy_meshlet_builder_unit.f =====
hw/rtl/gmb_pkg.sv
hw/rtl/gmb_cell.sv
hw/rtl/gmb_cell_row.sv
hw/rtl/greedy_meshlet_builder_unit.sv
hw/rtl/gmb_checker.sv
verif/testbench.sv
